[sv/tsb_pkg.sv]
// Package for the typed slot buffer: sizes, tag and opcode codes, sequencer states.
// No dependencies. The RTL files reference it by scoped names.
package tsb_pkg;

  localparam int unsigned SLOTS = 4;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    TAG_FREE = 2'd0,
    TAG_ONE  = 2'd1,
    TAG_TWO  = 2'd2
  } tag_e;

  typedef enum logic {
    OP_PRODUCE = 1'b0,
    OP_CONSUME = 1'b1
  } op_e;

  typedef enum logic {
    TYPE_ONE = 1'b0,
    TYPE_TWO = 1'b1
  } type_e;

  typedef enum logic {
    STATUS_DONE = 1'b0,
    STATUS_FAIL = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_RESP
  } state_e;

endpackage

[sv/tsb_req_if.sv]
// Request channel of the typed slot buffer: valid/ready plus the request fields.
// No dependencies.
interface tsb_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic               item_type;
  logic signed [31:0] value_in;

  modport source (output valid, output opcode, output item_type, output value_in,
                  input ready);
  modport sink   (input valid, input opcode, input item_type, input value_in,
                  output ready);
endinterface

[sv/tsb_res_if.sv]
// Result channel of the typed slot buffer: valid/ready plus the result fields.
// No dependencies.
interface tsb_res_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [1:0]         slot_index;
  logic signed [31:0] value_out;

  modport source (output valid, output status, output slot_index, output value_out,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input value_out,
                  output ready);
endinterface

[sv/tsb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tsb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [Width-1:0]          wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/typed_slot_buffer.sv]
// Typed slot buffer top level: tag flops, slot value RAM and a scanning sequencer.
// Depends on tsb_pkg, tsb_req_if, tsb_res_if and tsb_ram.
//
//  channel  dir  handshake          payload
//  req_i    in   valid/ready        opcode, item_type, value_in
//  res_o    out  valid/ready        status, slot_index, value_out
//
// One request at a time. A shared tag comparator walks the slots one per
// cycle from slot 0 and stops at the first hit or after the last slot;
// a consume hit then passes S_READ for the RAM read before S_RESP. The
// result register holds until res_o.ready; the next request can be taken
// the cycle after. Reset frees all slots at once; slot values are not
// cleared.
module typed_slot_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsb_req_if.sink    req_i,
  tsb_res_if.source  res_o
);

  tsb_pkg::state_e             state_q, state_d;
  logic [tsb_pkg::IDX_W-1:0]   idx_q, idx_d;
  tsb_pkg::op_e                op_q;
  tsb_pkg::type_e              type_q;
  logic [tsb_pkg::VAL_W-1:0]   val_q;
  tsb_pkg::tag_e               tag_q [tsb_pkg::SLOTS];

  tsb_pkg::status_e            status_q, status_d;
  logic [1:0]                  slot_idx_q, slot_idx_d;
  logic [tsb_pkg::VAL_W-1:0]   value_q, value_d;

  tsb_pkg::tag_e               want_tag, type_tag;
  logic                        hit, last;
  logic                        tag_we;
  tsb_pkg::tag_e               tag_wval;
  logic                        ram_we, ram_re;
  logic [tsb_pkg::VAL_W-1:0]   ram_rdata;
  logic                        req_acc;

  assign req_acc  = req_i.valid && req_i.ready;
  assign type_tag = (type_q == tsb_pkg::TYPE_TWO) ? tsb_pkg::TAG_TWO : tsb_pkg::TAG_ONE;
  assign want_tag = (op_q == tsb_pkg::OP_PRODUCE) ? tsb_pkg::TAG_FREE : type_tag;
  // shared comparator: one slot tag per cycle
  assign hit      = (tag_q[idx_q] == want_tag);
  assign last     = (idx_q == tsb_pkg::IDX_W'(tsb_pkg::SLOTS - 1));

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    status_d   = status_q;
    slot_idx_d = slot_idx_q;
    value_d    = value_q;
    tag_we     = 1'b0;
    tag_wval   = tsb_pkg::TAG_FREE;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    req_i.ready = 1'b0;
    res_o.valid = 1'b0;
    unique case (state_q)
      tsb_pkg::S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_acc) begin
          idx_d   = '0;
          state_d = tsb_pkg::S_SCAN;
        end
      end
      tsb_pkg::S_SCAN: begin
        if (hit) begin
          tag_we     = 1'b1;
          status_d   = tsb_pkg::STATUS_DONE;
          slot_idx_d = 2'(idx_q);
          value_d    = '0;
          if (op_q == tsb_pkg::OP_PRODUCE) begin
            tag_wval = type_tag;
            ram_we   = 1'b1;
            state_d  = tsb_pkg::S_RESP;
          end else begin
            tag_wval = tsb_pkg::TAG_FREE;
            ram_re   = 1'b1;
            state_d  = tsb_pkg::S_READ;
          end
        end else if (last) begin
          status_d   = tsb_pkg::STATUS_FAIL;
          slot_idx_d = '0;
          value_d    = '0;
          state_d    = tsb_pkg::S_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      tsb_pkg::S_READ: begin
        value_d = ram_rdata;
        state_d = tsb_pkg::S_RESP;
      end
      tsb_pkg::S_RESP: begin
        res_o.valid = 1'b1;
        if (res_o.ready) begin
          state_d = tsb_pkg::S_IDLE;
        end
      end
      default: state_d = tsb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsb_pkg::S_IDLE;
      idx_q   <= '0;
      for (int i = 0; i < tsb_pkg::SLOTS; i++) begin
        tag_q[i] <= tsb_pkg::TAG_FREE;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (tag_we) begin
        tag_q[idx_q] <= tag_wval;
      end
    end
  end

  // payload and result registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q   <= tsb_pkg::op_e'(req_i.opcode);
      type_q <= tsb_pkg::type_e'(req_i.item_type);
      val_q  <= req_i.value_in;
    end
    status_q   <= status_d;
    slot_idx_q <= slot_idx_d;
    value_q    <= value_d;
  end

  tsb_ram #(
    .Width (tsb_pkg::VAL_W),
    .Depth (tsb_pkg::SLOTS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign res_o.status     = status_q;
  assign res_o.slot_index = slot_idx_q;
  assign res_o.value_out  = value_q;

endmodule
